// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the sorted set table
// Key and count widths, request and status codes, cell control structs.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } req_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // shift commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_cmd_t;

  // per-cell compare results
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_stat_t;

endpackage

// ===== rtl/sst_req_if.sv =====
// ----------------------------------------------------------------------------
// sst_req_if: request channel
// Valid/ready handshake carrying operation and key.
// ----------------------------------------------------------------------------
interface sst_req_if;
  import sst_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  req_type;
  logic [KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink   (input valid, input req_type, input key, output ready);
endinterface

// ===== rtl/sst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sst_rsp_if: response channel
// Valid/ready handshake carrying status, found flag and occupancy.
// ----------------------------------------------------------------------------
interface sst_rsp_if;
  import sst_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output found, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input found, input occupancy,
                  output ready);
endinterface

// ===== rtl/sst_cell.sv =====
// ----------------------------------------------------------------------------
// sst_cell: one slot of the sorted key row
// Holds one key, compares it with the request key and shifts with neighbors.
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic                       clk,
  input  sst_pkg::cell_cmd_t         cmd,
  input  logic [sst_pkg::KEY_W-1:0]  req_key,
  input  logic                       occ,
  input  logic                       left_lt,
  input  logic [sst_pkg::KEY_W-1:0]  left_key,
  input  logic [sst_pkg::KEY_W-1:0]  right_key,
  output logic [sst_pkg::KEY_W-1:0]  stored_key,
  output sst_pkg::cell_stat_t        stat
);
  import sst_pkg::*;

  assign stat.lt = occ && (stored_key < req_key);
  assign stat.eq = occ && (stored_key == req_key);

  // cells below the insert/remove point keep their key
  always_ff @(posedge clk) begin
    if (cmd.ins && !stat.lt) begin
      // first cell not below the key takes it, the rest shift up
      stored_key <= left_lt ? req_key : left_key;
    end else if (cmd.rem && !stat.lt) begin
      stored_key <= right_key;
    end
  end

endmodule

// ===== rtl/sorted_set_table_unit.sv =====
// The response is registered and is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while no response waits untaken; the whole
//   row of compare cells resolves the position and shifts its keys in the accepting cycle.
// Reset clears the key count and the response valid flag; the key cells are
//   not reset and are only read below the count.
// ----------------------------------------------------------------------------
// sorted_set_table_unit: ordered set of distinct keys
// Insert, remove and lookup on a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module sorted_set_table_unit (
  input  logic      clk,
  input  logic      rst,
  sst_req_if.sink   req,
  sst_rsp_if.source rsp
);
  import sst_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             present;
  logic             full;
  status_t          status_next;
  cell_cmd_t        cmd;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] eq_vec;
  logic [KEY_W-1:0]    keys [CAPACITY];
  cell_stat_t          stats [CAPACITY];

  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic             left_lt;
      logic [KEY_W-1:0] left_key;
      logic [KEY_W-1:0] right_key;

      assign occ[gi]    = CNT_W'(gi) < count;
      assign eq_vec[gi] = stats[gi].eq;

      if (gi == 0) begin : g_first
        assign left_lt  = 1'b1;
        assign left_key = keys[gi];
      end else begin : g_mid
        assign left_lt  = stats[gi-1].lt;
        assign left_key = keys[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_last
        assign right_key = keys[gi];
      end else begin : g_inner
        assign right_key = keys[gi+1];
      end

      sst_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .req_key    (req.key),
        .occ        (occ[gi]),
        .left_lt    (left_lt),
        .left_key   (left_key),
        .right_key  (right_key),
        .stored_key (keys[gi]),
        .stat       (stats[gi])
      );
    end
  endgenerate

  assign present = |eq_vec;
  assign full    = count == CNT_W'(CAPACITY);

  always_comb begin
    cmd         = '0;
    count_next  = count;
    status_next = present ? ST_OK : ST_ABSENT;
    case (req.req_type)
      OP_INSERT: begin
        if (present) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          cmd.ins     = accept;
          count_next  = count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (present) begin
          cmd.rem    = accept;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        // lookup, and the unused code behaves as lookup
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status    <= status_next;
      rsp.found     <= present;
      rsp.occupancy <= OCC_W'(count_next);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("key count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    accept && req.req_type == OP_INSERT && !present && !full
    |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  assert property (@(posedge clk) disable iff (rst)
    accept && (req.req_type == OP_REMOVE || req.req_type == OP_LOOKUP) && !present
    |=> count == $past(count))
    else $error("miss changed the count");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_DUP |-> rsp.found)
    else $error("duplicate reported without found");

  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_FULL |-> !rsp.found && count == CNT_W'(CAPACITY))
    else $error("full reported on a table with room");

endmodule
